[hw/rtl/wia_pkg.sv]
`timescale 1ns / 1ps
package wia_pkg;
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_SHL = 3'd4,
		OP_SHR = 3'd5,
		OP_CMP = 3'd6,
		OP_NOP = 3'd7
	} op_t;

	typedef struct packed {
		logic load;
		logic iter;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic multi;
		logic last;
	} dp_stat_t;
endpackage

[hw/rtl/wia_ctrl.sv]
`timescale 1ns / 1ps
module wia_ctrl import wia_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat,
	output logic     done
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_ITER = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.multi) state_d = S_ITER;
				else state_d = S_FIN;
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				if (stat.last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.finish;
	end
endmodule

[hw/rtl/wia_dp.sv]
`timescale 1ns / 1ps
module wia_dp import wia_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic              clk,
	input  logic [2:0]        req_type,
	input  logic [63:0]       operand_a,
	input  logic [63:0]       operand_b,
	input  logic [7:0]        shift_amount,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic [63:0]       result_value,
	output logic [62:0]       remainder_value,
	output logic [1:0]        compare_result,
	output logic              divide_by_zero
);
	localparam int CW = $clog2(WIDTH + 1);

	op_t              op_q;
	logic [WIDTH-1:0] a_q, b_q, acc_q, rem_q, quo_q, mb_q;
	logic [7:0]       sh_q;
	logic [CW-1:0]    cnt_q;
	logic             qneg_q;

	logic [WIDTH-1:0] a_w, b_w, ma, mb;
	assign a_w = operand_a[WIDTH-1:0];
	assign b_w = operand_b[WIDTH-1:0];
	assign ma = a_w[WIDTH-1] ? -a_w : a_w;
	assign mb = b_w[WIDTH-1] ? -b_w : b_w;

	assign stat.multi = (op_q == OP_MUL) || (op_q == OP_DIV && mb_q != '0);
	assign stat.last = (cnt_q == CW'(WIDTH - 1));

	// one bit per iteration: shift-add multiply, restoring divide
	logic [WIDTH:0]   trial;
	logic [WIDTH-1:0] rem_sh;
	assign rem_sh = {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
	assign trial = {rem_q[WIDTH-1], rem_sh} - {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(req_type);
			a_q <= a_w;
			b_q <= b_w;
			sh_q <= shift_amount;
			acc_q <= '0;
			rem_q <= '0;
			quo_q <= ma;
			mb_q <= mb;
			qneg_q <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
			cnt_q <= '0;
		end else if (cmd.iter) begin
			cnt_q <= cnt_q + 1'b1;
			if (op_q == OP_MUL) begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else begin
				if (!trial[WIDTH]) begin
					rem_q <= trial[WIDTH-1:0];
					quo_q <= {quo_q[WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	// final selection
	logic [WIDTH-1:0] res_w, mag_a, shv;
	logic [63:0]      rem_w;
	logic [1:0]       cmp_w;
	logic             dz_w, sneg, left;
	logic [7:0]       smag;

	assign mag_a = a_q[WIDTH-1] ? -a_q : a_q;
	assign sneg = sh_q[7];
	assign smag = sneg ? -sh_q : sh_q;
	assign left = (op_q == OP_SHL) != sneg;
	assign shv = (smag >= 8'(WIDTH)) ? '0 : (left ? a_q << smag : a_q >> smag);

	always_comb begin
		res_w = '0;
		rem_w = '0;
		cmp_w = '0;
		dz_w = 1'b0;
		case (op_q) inside
			OP_ADD: res_w = a_q + b_q;
			OP_SUB: res_w = a_q - b_q;
			OP_MUL: res_w = acc_q;
			OP_DIV: begin
				if (mb_q == '0) begin
					dz_w = 1'b1;
					rem_w = 64'(mag_a);
					if (rem_w[63]) rem_w = {1'b0, {63{1'b1}}};
				end else begin
					res_w = qneg_q ? -quo_q : quo_q;
					rem_w = 64'(rem_q);
				end
			end
			OP_SHL, OP_SHR: res_w = shv;
			OP_CMP: begin
				if ($signed(a_q) < $signed(b_q)) cmp_w = 2'b11;
				else if (a_q != b_q) cmp_w = 2'b01;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_value <= {{(64-WIDTH){res_w[WIDTH-1]}}, res_w};
			remainder_value <= rem_w[62:0];
			compare_result <= cmp_w;
			divide_by_zero <= dz_w;
		end
	end
endmodule

[hw/rtl/wide_integer_alu.sv]
`timescale 1ns / 1ps
// steps: load, iterate (mul and nonzero-divisor div only), finish, which registers the result
// one item in flight; mul and div iterate one bit a cycle
// result shows for one cycle with result_valid; the receiver cannot stall
// reset (arst_n low) returns the controller to idle and clears result_valid
module wide_integer_alu import wia_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [7:0]  shift_amount,
	output logic        result_valid,
	output logic [63:0] result_value,
	output logic [62:0] remainder_value,
	output logic [1:0]  compare_result,
	output logic        divide_by_zero
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	wia_ctrl #(.WIDTH(WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat), .done(result_valid)
	);

	wia_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .req_type(req_type), .operand_a(operand_a),
		.operand_b(operand_b), .shift_amount(shift_amount),
		.cmd(cmd), .stat(stat), .result_value(result_value),
		.remainder_value(remainder_value), .compare_result(compare_result),
		.divide_by_zero(divide_by_zero)
	);
endmodule

[tb/wide_integer_alu_checker.sv]
`timescale 1ns / 1ps
module wide_integer_alu_checker import wia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [7:0]  shift_amount,
	input  logic        result_valid,
	input  logic [63:0] result_value,
	input  logic [62:0] remainder_value,
	input  logic [1:0]  compare_result,
	input  logic        divide_by_zero,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [63:0] value;
		logic [62:0] rem;
		logic [1:0]  cmp;
		logic        dz;
	} alu_answer_t;

	alu_answer_t answers_due[$];

	function automatic alu_answer_t compute_alu(op_t op, logic [63:0] a, logic [63:0] b,
			logic [7:0] sh);
		alu_answer_t r;
		logic [63:0] ma, mb, q;
		logic [7:0] mag;
		logic left;
		r = '0;
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: r.value = a * b;
			OP_DIV: begin
				ma = a[63] ? -a : a;
				mb = b[63] ? -b : b;
				if (mb == 0) begin
					r.dz = 1'b1;
					r.rem = ma[63] ? {63{1'b1}} : ma[62:0];
				end else begin
					q = ma / mb;
					r.rem = 63'(ma % mb);
					r.value = (a[63] != b[63]) ? -q : q;
				end
			end
			OP_SHL, OP_SHR: begin
				mag = sh[7] ? 8'(9'h100 - sh) : sh;
				left = (op == OP_SHL) != sh[7];
				if (mag >= 64) r.value = '0;
				else if (left) r.value = a << mag;
				else r.value = a >> mag;
			end
			OP_CMP: begin
				if ($signed(a) < $signed(b)) r.cmp = 2'b11;
				else if ($signed(a) > $signed(b)) r.cmp = 2'b01;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	assign pending = answers_due.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		alu_answer_t want, got;
		if (arst_n) begin
			if (result_valid) begin
				got = '{result_value, remainder_value, compare_result, divide_by_zero};
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: result_value exp %h got %h", $time, want.value, got.value);
						fail_count++;
					end
					if (got.rem !== want.rem) begin
						$display("%0t: remainder_value exp %h got %h", $time, want.rem, got.rem);
						fail_count++;
					end
					if (got.cmp !== want.cmp) begin
						$display("%0t: compare_result exp %b got %b", $time, want.cmp, got.cmp);
						fail_count++;
					end
					if (got.dz !== want.dz) begin
						$display("%0t: divide_by_zero exp %b got %b", $time, want.dz, got.dz);
						fail_count++;
					end
				end
			end
			// a transfer pushed after the pop so a same-edge result takes the older one
			if (start && !busy)
				answers_due.push_back(compute_alu(op_t'(req_type), operand_a, operand_b,
					shift_amount));
		end
	end
endmodule

[tb/wide_integer_alu_test.sv]
`timescale 1ns / 1ps
module wide_integer_alu_test import wia_pkg::*;;
	logic clk, arst_n, start, busy, result_valid, divide_by_zero;
	logic [2:0] req_type;
	logic [63:0] operand_a, operand_b, result_value;
	logic [7:0] shift_amount;
	logic [62:0] remainder_value;
	logic [1:0] compare_result;
	int fail_count, pending, quiet_cycles, idle_pct;
	localparam int WATCHDOG = 2000;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

	wide_integer_alu #(.WIDTH(64)) u_top (.*);
	wide_integer_alu_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles with no transfer and no result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("wide_integer_alu_test: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'($signed($urandom_range(0, 20)) - 10);
			3: return {32'h0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// busy is steady at the falling edge, so start raised there is taken at the next rising edge
	task automatic send_op(op_t op, logic [63:0] a, logic [63:0] b, logic [7:0] sh);
		while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
		while (busy) @(negedge clk);
		start <= 1'b1;
		req_type <= op;
		operand_a <= a;
		operand_b <= b;
		shift_amount <= sh;
		@(negedge clk);
		start <= 1'b0;
	endtask

	initial begin
		logic [7:0] sh;
		op_t op;
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 0;
		start = 0;
		req_type = OP_ADD;
		operand_a = '0;
		operand_b = '0;
		shift_amount = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_op(OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1, 8'd0);
		send_op(OP_ADD, '1, '1, 8'hff);
		send_op(OP_SUB, MOST_NEG, 64'd1, 8'd0);
		send_op(OP_MUL, MOST_NEG, '1, 8'd0);
		send_op(OP_MUL, 64'h1234_5678_9abc_def0, 64'hfedc_ba98_7654_3210, 8'd0);
		send_op(OP_DIV, 64'd100, 64'd0, 8'd0);
		send_op(OP_DIV, MOST_NEG, 64'd0, 8'd0);
		send_op(OP_DIV, MOST_NEG, '1, 8'd0);
		send_op(OP_DIV, -64'sd7, 64'd2, 8'd0);
		send_op(OP_DIV, 64'd7, -64'sd2, 8'd0);
		send_op(OP_SHL, '1, '0, 8'd63);
		send_op(OP_SHL, '1, '0, 8'd64);
		send_op(OP_SHL, '1, '0, 8'hc0);
		send_op(OP_SHR, '1, '0, 8'hc1);
		send_op(OP_SHR, '1, '0, 8'h80);
		send_op(OP_SHR, MOST_NEG, '0, 8'hff);
		send_op(OP_CMP, MOST_NEG, 64'h7fff_ffff_ffff_ffff, 8'd0);
		send_op(OP_CMP, '1, '1, 8'd0);
		send_op(OP_CMP, 64'd5, -64'sd5, 8'd0);
		send_op(OP_NOP, '1, '1, 8'hff);
		for (int i = 0; i < 950; i++) begin
			case (i / 240)
				0: idle_pct = 0;
				1: idle_pct = 68;
				2: idle_pct = 0;
				default: idle_pct = 13;
			endcase
			op = op_t'(3'($urandom_range(0, 7)));
			sh = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 128) - 64);
			send_op(op, pick_operand(), $urandom_range(0, 9) == 0 ? '0 : pick_operand(), sh);
		end
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0) $display("wide_integer_alu_test: PASS");
		else $display("wide_integer_alu_test: FAIL");
		$finish;
	end
endmodule
